### rtl/xbm_pkg.sv
`default_nettype none
package xbm_pkg;

	localparam int MAX_DIM_DEFAULT = 4096;
	localparam int CFG_W = 13;
	localparam int CFG_INDEX_W = 2;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [4:0] SHORT_BITS = 5'd16;
	localparam logic [4:0] CHAR_BITS = 5'd8;

	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_NUL = 8'h00;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_IMAGE_WIDTH = 2'd0,
		CFG_IMAGE_HEIGHT = 2'd1,
		CFG_WORD_FORMAT = 2'd2
	} cfg_index_t;

	typedef struct packed {
		logic [7:0] ch;
		logic frame_start;
	} in_item_t;

	typedef struct packed {
		logic [11:0] row_index;
		logic [11:0] col_start;
		logic [15:0] pixel_bits;
		logic [4:0] pixel_count;
		logic image_done;
	} out_item_t;

	// One command from the lexer to the placer: either a frame restart or a
	// finished value.
	typedef struct packed {
		logic is_clear;
		logic [15:0] value;
	} cmd_t;

	typedef struct packed {
		logic is_delim;
		logic is_skip;
		logic [3:0] digit;
	} char_class_t;

	function automatic char_class_t classify(input logic [7:0] c);
		char_class_t r;
		r.is_delim = 1'b0;
		r.is_skip = 1'b0;
		r.digit = 4'd0;
		if (c == CH_COMMA || c == CH_NEWLINE) begin
			r.is_delim = 1'b1;
		end else if (c >= 8'h30 && c <= 8'h39) begin
			r.digit = 4'(c - 8'h30);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r.digit = 4'(c - 8'h57);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r.digit = 4'(c - 8'h37);
		end else if (c == CH_SPACE || c == CH_TAB || c == CH_RBRACE || c == CH_NUL) begin
			r.is_skip = 1'b1;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

### rtl/xbm_hex_data_decoder_top.sv
// Decodes the data section of an XBM bitmap into runs of pixels.
// Input channel (in_valid/in_stall/in_data): one character per transfer, starting
// after the opening brace. Setting frame_start restarts the row, column and token
// state before that character is taken.
// Output channel (out_valid/out_stall/out_data): one transfer per finished value in
// the image, carrying row, first column, up to 16 pixel bits (LSB first, 1 = black),
// the pixel count and a flag on the transfer that completes the last row.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 width, 1 height,
// 2 word format); write only while the block is idle.
// Throughput is one character per cycle while in_stall is low. The value that a
// character ends is pushed by the lexer into the two-entry command queue, then
// taken by the placer into the output register.
// When the receiver stalls, the output register holds its transfer, the queue
// fills, and in_stall rises once the queue is full.
// Reset gives width 1, height 1, 16-bit words, row and column zero, empty queue.
`default_nettype none
module xbm_hex_data_decoder_top #(
	parameter int MAX_DIM = xbm_pkg::MAX_DIM_DEFAULT
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire xbm_pkg::in_item_t in_data,
	output logic out_valid,
	input wire logic out_stall,
	output xbm_pkg::out_item_t out_data,
	input wire logic cfg_we,
	input wire logic [xbm_pkg::CFG_INDEX_W-1:0] cfg_index,
	input wire logic [xbm_pkg::CFG_W-1:0] cfg_data
);

	logic [xbm_pkg::CFG_W-1:0] image_width_q;
	logic [xbm_pkg::CFG_W-1:0] image_height_q;
	logic word_format_q;

	logic queue_full;
	logic push;
	xbm_pkg::cmd_t push_cmd;
	logic pop;
	logic pop_valid;
	xbm_pkg::cmd_t pop_cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q <= xbm_pkg::CFG_W'(1);
			image_height_q <= xbm_pkg::CFG_W'(1);
			word_format_q <= 1'b0;
		end else if (cfg_we) begin
			case (xbm_pkg::cfg_index_t'(cfg_index))
				xbm_pkg::CFG_IMAGE_WIDTH: begin
					image_width_q <= cfg_data;
				end
				xbm_pkg::CFG_IMAGE_HEIGHT: begin
					image_height_q <= cfg_data;
				end
				xbm_pkg::CFG_WORD_FORMAT: begin
					word_format_q <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	xbm_lexer u_lexer (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.queue_full(queue_full),
		.push(push),
		.push_cmd(push_cmd)
	);

	xbm_cmd_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_cmd(push_cmd),
		.full(queue_full),
		.pop(pop),
		.pop_valid(pop_valid),
		.pop_cmd(pop_cmd)
	);

	xbm_placer #(
		.MAX_DIM(MAX_DIM)
	) u_placer (
		.clk(clk),
		.arst_n(arst_n),
		.image_width(image_width_q),
		.image_height(image_height_q),
		.word_format(word_format_q),
		.cmd_valid(pop_valid),
		.cmd(pop_cmd),
		.cmd_pop(pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

endmodule
`default_nettype wire

### rtl/xbm_lexer.sv
`default_nettype none
module xbm_lexer (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire xbm_pkg::in_item_t in_data,
	input wire logic queue_full,
	output logic push,
	output xbm_pkg::cmd_t push_cmd
);

	logic [15:0] acc_q;
	logic have_q;
	logic skip_q;

	logic accept;
	xbm_pkg::char_class_t cls;
	logic [15:0] acc_e;
	logic have_e;
	logic skip_e;
	logic [15:0] acc_n;
	logic have_n;
	logic skip_n;
	logic value_done;

	assign in_stall = queue_full;
	assign accept = in_valid && !queue_full;
	assign cls = xbm_pkg::classify(in_data.ch);

	always_comb begin
		// A frame start wipes the token state before the character is looked at.
		acc_e = in_data.frame_start ? 16'd0 : acc_q;
		have_e = in_data.frame_start ? 1'b0 : have_q;
		skip_e = in_data.frame_start ? 1'b0 : skip_q;
		acc_n = acc_e;
		have_n = have_e;
		skip_n = skip_e;
		value_done = 1'b0;
		if (cls.is_delim) begin
			value_done = have_e && !skip_e;
			acc_n = 16'd0;
			have_n = 1'b0;
			skip_n = 1'b0;
		end else if (!skip_e) begin
			if (!cls.is_skip) begin
				acc_n = {acc_e[11:0], cls.digit};
				have_n = 1'b1;
			end else if (have_e) begin
				value_done = 1'b1;
				skip_n = 1'b1;
				have_n = 1'b0;
			end
		end
	end

	assign push = accept && (in_data.frame_start || value_done);
	assign push_cmd.is_clear = in_data.frame_start;
	assign push_cmd.value = acc_e;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= 16'd0;
			have_q <= 1'b0;
			skip_q <= 1'b0;
		end else if (accept) begin
			acc_q <= acc_n;
			have_q <= have_n;
			skip_q <= skip_n;
		end
	end

endmodule
`default_nettype wire

### rtl/xbm_cmd_fifo.sv
`default_nettype none
module xbm_cmd_fifo (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire xbm_pkg::cmd_t push_cmd,
	output logic full,
	input wire logic pop,
	output logic pop_valid,
	output xbm_pkg::cmd_t pop_cmd
);

	localparam int PTR_W = (xbm_pkg::QUEUE_DEPTH > 1) ? $clog2(xbm_pkg::QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(xbm_pkg::QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(xbm_pkg::QUEUE_DEPTH - 1);

	xbm_pkg::cmd_t mem_q [xbm_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic do_pop;

	assign full = (count_q == CNT_W'(xbm_pkg::QUEUE_DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_cmd = mem_q[rd_ptr_q];
	assign do_pop = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

### rtl/xbm_placer.sv
`default_nettype none
module xbm_placer #(
	parameter int MAX_DIM = xbm_pkg::MAX_DIM_DEFAULT
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [xbm_pkg::CFG_W-1:0] image_width,
	input wire logic [xbm_pkg::CFG_W-1:0] image_height,
	input wire logic word_format,
	input wire logic cmd_valid,
	input wire xbm_pkg::cmd_t cmd,
	output logic cmd_pop,
	output logic out_valid,
	input wire logic out_stall,
	output xbm_pkg::out_item_t out_data
);

	localparam int CW = xbm_pkg::CFG_W;

	logic [CW-1:0] cur_row_q;
	logic [CW-1:0] cur_col_q;
	logic out_valid_q;
	xbm_pkg::out_item_t out_data_q;

	logic [CW-1:0] w_eff;
	logic [CW-1:0] h_eff;
	logic row_ok;
	logic [CW-1:0] row0;
	logic [CW-1:0] col0;
	logic produce;
	logic [CW-1:0] rem;
	logic [4:0] word_bits;
	logic [4:0] n;
	logic [15:0] mask;
	logic [CW-1:0] col_sum;
	logic [CW-1:0] row_new;
	logic [CW-1:0] col_new;

	always_comb begin
		if (image_width == '0) begin
			w_eff = CW'(1);
		end else if (32'(image_width) > 32'(MAX_DIM)) begin
			w_eff = CW'(MAX_DIM);
		end else begin
			w_eff = image_width;
		end
		h_eff = (32'(image_height) > 32'(MAX_DIM)) ? CW'(MAX_DIM) : image_height;
	end

	always_comb begin
		row_ok = cur_row_q < h_eff;
		// A column left at or past the width by a register change closes the row first.
		if (cur_col_q >= w_eff) begin
			row0 = cur_row_q + CW'(1);
			col0 = '0;
		end else begin
			row0 = cur_row_q;
			col0 = cur_col_q;
		end
		produce = row_ok && (row0 < h_eff);
		rem = w_eff - col0;
		word_bits = word_format ? xbm_pkg::CHAR_BITS : xbm_pkg::SHORT_BITS;
		n = (rem > CW'(word_bits)) ? word_bits : rem[4:0];
		mask = (n == xbm_pkg::SHORT_BITS) ? 16'hFFFF : ((16'd1 << n) - 16'd1);
		col_sum = col0 + CW'(n);
		if (col_sum >= w_eff) begin
			col_new = '0;
			row_new = row0 + CW'(1);
		end else begin
			col_new = col_sum;
			row_new = row0;
		end
	end

	assign cmd_pop = cmd_valid && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_row_q <= '0;
			cur_col_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd_pop && !cmd.is_clear && produce) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cmd_pop) begin
				if (cmd.is_clear) begin
					cur_row_q <= '0;
					cur_col_q <= '0;
				end else if (row_ok) begin
					if (produce) begin
						cur_row_q <= row_new;
						cur_col_q <= col_new;
					end else begin
						cur_row_q <= row0;
						cur_col_q <= col0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop && !cmd.is_clear && produce) begin
			out_data_q.row_index <= row0[11:0];
			out_data_q.col_start <= col0[11:0];
			out_data_q.pixel_bits <= cmd.value & mask;
			out_data_q.pixel_count <= n;
			out_data_q.image_done <= (row_new == h_eff);
		end
	end

endmodule
`default_nettype wire
